// ===== rtl/hka_pkg.sv =====
// Package for the HKA locus chi-square block: word types, fixed-point constants,
// and the harmonic and inverse-square sum tables. No dependencies.
package hka_pkg;

	localparam int MAX_SAMPLES = 256;
	localparam int FRAC_BITS   = 16;
	localparam int IDX_W       = $clog2(MAX_SAMPLES);
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);

	localparam logic [63:0] CAP = (64'd1 << 62) - 64'd1;
	localparam logic [47:0] M48 = '1;
	localparam logic [63:0] ONE24 = 64'd1 << 24;

	localparam logic [1:0] REG_T_HAT = 2'd0;
	localparam logic [1:0] REG_F_HAT = 2'd1;
	localparam logic [1:0] REG_TWO   = 2'd2;

	typedef logic [31:0] rom_t [MAX_SAMPLES];

	typedef struct packed {
		logic [31:0] theta;
		logic [19:0] locus_length;
		logic [8:0]  samples_a;
		logic [8:0]  samples_b;
		logic [19:0] seg_sites_a;
		logic [19:0] seg_sites_b;
		logic [31:0] divergence;
		logic        last_locus;
	} item_t;

	typedef struct packed {
		logic [47:0] chi_locus;
		logic [47:0] expected_sa;
		logic [47:0] expected_d;
		logic [47:0] chi_total;
		logic        invalid;
		logic        last_out;
	} result_t;

	typedef struct packed {
		logic [31:0] theta;
		logic [19:0] locus_length;
		logic [31:0] harm_a;
		logic [31:0] isq_a;
		logic [31:0] harm_b;
		logic [31:0] isq_b;
		logic [19:0] seg_sites_a;
		logic [19:0] seg_sites_b;
		logic [31:0] divergence;
		logic        last_locus;
	} entry_t;

	typedef struct packed {
		logic [31:0] t_hat;
		logic [31:0] f_hat;
		logic        two_species;
	} cfg_t;

	// rounded num/den by shift-subtract, elaboration use only
	function automatic logic [63:0] div_round(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] rem;
		logic [63:0] q;
		logic [63:0] n;
		int i;
		n = num + (den >> 1);
		rem = '0;
		q = '0;
		for (i = 63; i >= 0; i--) begin
			rem = {rem[62:0], n[i]};
			q = {q[62:0], 1'b0};
			if (rem >= den) begin
				rem = rem - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic rom_t gen_rom(input logic squared);
		rom_t r;
		logic [63:0] k;
		logic [63:0] d;
		int i;
		r[0] = '0;
		for (i = 1; i < MAX_SAMPLES; i++) begin
			k = 64'(i);
			d = squared ? k * k : k;
			r[i] = r[i-1] + 32'(div_round(64'd1 << 28, d));
		end
		return r;
	endfunction

	localparam rom_t HARM_ROM = gen_rom(1'b0);
	localparam rom_t ISQ_ROM  = gen_rom(1'b1);

	function automatic logic [IDX_W-1:0] table_index(input logic [8:0] n);
		logic [IDX_W-1:0] r;
		if (32'(n) > MAX_SAMPLES)
			r = IDX_W'(MAX_SAMPLES - 1);
		else if (n == '0)
			r = '0;
		else
			r = IDX_W'(n - 9'd1);
		return r;
	endfunction

	function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, CAP}) ? CAP : s[63:0];
	endfunction

endpackage

// ===== rtl/hka_locus_chi_square.sv =====
// Top level of the HKA locus chi-square block: APB registers, front, queue, back.
// Depends on hka_pkg, hka_front, hka_queue, hka_back.
//
// One locus word in, one result word out. Each locus runs through eleven
// 64-bit fixed-point products and three squared deviations on one shared
// 32x32 multiplier, and up to three 64-step restoring divisions on one
// shared divider; a division is skipped when its variance is zero or the
// quotient saturates. A two-entry queue takes new loci while the back part
// works and while a result waits.
// Registers: t_hat at 0x0, f_hat at 0x4, two_species at 0x8; write them only
// while the block is idle. chi_total clears after a word with last_locus set.
module hka_locus_chi_square (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  logic             item_valid,
	output logic             item_stall,
	input  hka_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output hka_pkg::result_t result
);

	hka_pkg::cfg_t   cfg_q;
	hka_pkg::entry_t f_entry, q_data;
	logic            q_full, q_empty, q_pop, push;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.t_hat       <= '0;
			cfg_q.f_hat       <= 32'(hka_pkg::ONE24);
			cfg_q.two_species <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				hka_pkg::REG_T_HAT: cfg_q.t_hat       <= pwdata;
				hka_pkg::REG_F_HAT: cfg_q.f_hat       <= pwdata;
				hka_pkg::REG_TWO:   cfg_q.two_species <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			hka_pkg::REG_T_HAT: prdata = cfg_q.t_hat;
			hka_pkg::REG_F_HAT: prdata = cfg_q.f_hat;
			hka_pkg::REG_TWO:   prdata = {31'd0, cfg_q.two_species};
			default:            prdata = '0;
		endcase
	end

	assign item_stall = q_full;
	assign push       = item_valid & ~q_full;

	hka_front u_front (
		.item  (item),
		.entry (f_entry)
	);

	hka_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (f_entry),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_data)
	);

	hka_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.q_data       (q_data),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ===== rtl/hka_front.sv =====
// Front part: looks up the table sums for one locus word.
// Depends on hka_pkg.
module hka_front (
	input  hka_pkg::item_t  item,
	output hka_pkg::entry_t entry
);

	logic [hka_pkg::IDX_W-1:0] ia;
	logic [hka_pkg::IDX_W-1:0] ib;

	assign ia = hka_pkg::table_index(item.samples_a);
	assign ib = hka_pkg::table_index(item.samples_b);

	always_comb begin
		entry.theta        = item.theta;
		entry.locus_length = item.locus_length;
		entry.harm_a       = hka_pkg::HARM_ROM[ia];
		entry.isq_a        = hka_pkg::ISQ_ROM[ia];
		entry.harm_b       = hka_pkg::HARM_ROM[ib];
		entry.isq_b        = hka_pkg::ISQ_ROM[ib];
		entry.seg_sites_a  = item.seg_sites_a;
		entry.seg_sites_b  = item.seg_sites_b;
		entry.divergence   = item.divergence;
		entry.last_locus   = item.last_locus;
	end

endmodule

// ===== rtl/hka_queue.sv =====
// Short queue between front and back parts.
// Depends on hka_pkg.
module hka_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hka_pkg::entry_t wdata,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output hka_pkg::entry_t rdata
);

	hka_pkg::entry_t mem_q [hka_pkg::QDEPTH];
	logic [hka_pkg::QPTR_W-1:0] wp_q, rp_q;
	logic [hka_pkg::QPTR_W:0]   cnt_q;

	assign full  = (cnt_q == (hka_pkg::QPTR_W+1)'(hka_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/hka_back.sv =====
// Back part: sequencer over a shared 32x32 multiplier and a radix-2 divider,
// output register and running total. Depends on hka_pkg.
module hka_back (
	input  logic             clk,
	input  logic             arst_n,
	input  hka_pkg::cfg_t    cfg,
	input  logic             q_empty,
	input  hka_pkg::entry_t  q_data,
	output logic             q_pop,
	output logic             result_valid,
	input  logic             result_stall,
	output hka_pkg::result_t result
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_MFIN = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	localparam logic [3:0] OP_T   = 4'd0;
	localparam logic [3:0] OP_ESA = 4'd1;
	localparam logic [3:0] OP_XA  = 4'd2;
	localparam logic [3:0] OP_VSA = 4'd3;
	localparam logic [3:0] OP_TB  = 4'd4;
	localparam logic [3:0] OP_ESB = 4'd5;
	localparam logic [3:0] OP_XB  = 4'd6;
	localparam logic [3:0] OP_VSB = 4'd7;
	localparam logic [3:0] OP_ED  = 4'd8;
	localparam logic [3:0] OP_M   = 4'd9;
	localparam logic [3:0] OP_VD  = 4'd10;
	localparam logic [3:0] OP_DA  = 4'd11;
	localparam logic [3:0] OP_DB  = 4'd12;
	localparam logic [3:0] OP_DD  = 4'd13;

	localparam logic [6:0] SH_T  = 7'(24 - hka_pkg::FRAC_BITS);
	localparam logic [6:0] SH_F  = 7'(hka_pkg::FRAC_BITS);
	localparam logic [6:0] SH_28 = 7'd28;
	localparam logic [6:0] SH_24 = 7'd24;
	localparam logic [6:0] SH_25 = 7'd25;

	state_t          st_q;
	logic [3:0]      op_q;
	logic [1:0]      mcnt_q;
	logic [5:0]      dcnt_q;
	hka_pkg::entry_t ent_q;
	logic [127:0]    acc_q;
	logic [63:0]     t_q, tb_q, x_q, esa_q, vsa_q, esb_q, vsb_q, ed_q, vd_q;
	logic [63:0]     da_q, db_q, dd_q;
	logic [63:0]     rem_q, lo_q, quo_q;
	logic            za_q, zb_q, nb_q, zd_q;
	logic [47:0]     total_q;

	logic [63:0]  fr, half, obs_a, obs_b, obs_d, dif_a, dif_b, dif_d;
	logic [63:0]  opa, opb, var_cur, sat, rem_n, quo_n, chi_sum;
	logic [6:0]   sh;
	logic [31:0]  ah, bh;
	logic [63:0]  pp;
	logic [127:0] pp_sh, res;
	logic         ge, bad, out_free;
	logic [47:0]  chi48, tot48;
	logic [48:0]  tot_sum;

	assign fr    = cfg.two_species ? 64'(cfg.f_hat) : hka_pkg::ONE24;
	assign half  = fr + hka_pkg::ONE24;
	assign obs_a = 64'(ent_q.seg_sites_a) << hka_pkg::FRAC_BITS;
	assign obs_b = 64'(ent_q.seg_sites_b) << hka_pkg::FRAC_BITS;
	assign obs_d = (64'(ent_q.divergence) << hka_pkg::FRAC_BITS) >> 8;
	assign dif_a = (obs_a > esa_q) ? obs_a - esa_q : esa_q - obs_a;
	assign dif_b = (obs_b > esb_q) ? obs_b - esb_q : esb_q - obs_b;
	assign dif_d = (obs_d > ed_q) ? obs_d - ed_q : ed_q - obs_d;

	always_comb begin
		opa = '0;
		opb = '0;
		sh  = '0;
		var_cur = vd_q;
		case (op_q)
			OP_T:   begin opa = 64'(ent_q.theta); opb = 64'(ent_q.locus_length); sh = SH_T; end
			OP_ESA: begin opa = t_q;  opb = 64'(ent_q.harm_a); sh = SH_28; end
			OP_XA:  begin opa = t_q;  opb = t_q;  sh = SH_F; end
			OP_VSA: begin opa = x_q;  opb = 64'(ent_q.isq_a); sh = SH_28; end
			OP_TB:  begin opa = t_q;  opb = fr;   sh = SH_24; end
			OP_ESB: begin opa = tb_q; opb = 64'(ent_q.harm_b); sh = SH_28; end
			OP_XB:  begin opa = tb_q; opb = tb_q; sh = SH_F; end
			OP_VSB: begin opa = x_q;  opb = 64'(ent_q.isq_b); sh = SH_28; end
			OP_ED:  begin opa = t_q;  opb = (64'(cfg.t_hat) << 1) + half; sh = SH_25; end
			OP_M:   begin opa = t_q;  opb = half; sh = SH_25; end
			OP_VD:  begin opa = x_q;  opb = x_q;  sh = SH_F; end
			OP_DA:  begin opa = dif_a; opb = dif_a; var_cur = vsa_q; end
			OP_DB:  begin opa = dif_b; opb = dif_b; var_cur = vsb_q; end
			OP_DD:  begin opa = dif_d; opb = dif_d; var_cur = vd_q; end
			default: begin opa = '0; opb = '0; end
		endcase
	end

	assign ah    = mcnt_q[1] ? opa[63:32] : opa[31:0];
	assign bh    = mcnt_q[0] ? opb[63:32] : opb[31:0];
	assign pp    = 64'(ah) * 64'(bh);
	assign pp_sh = {64'd0, pp} << {mcnt_q[1] & mcnt_q[0], mcnt_q[1] ^ mcnt_q[0], 5'd0};
	assign res   = acc_q >> sh;
	assign sat   = (|res[127:62]) ? hka_pkg::CAP : res[63:0];

	assign rem_n = {rem_q[62:0], lo_q[63]};
	assign ge    = (rem_n >= var_cur);
	assign quo_n = {quo_q[62:0], ge};

	assign bad     = za_q | zd_q | (zb_q & ~nb_q);
	assign chi_sum = da_q + db_q + dd_q;
	assign chi48   = (bad || chi_sum > 64'(hka_pkg::M48)) ? hka_pkg::M48 : chi_sum[47:0];
	assign tot_sum = {1'b0, total_q} + {1'b0, chi48};
	assign tot48   = (bad || tot_sum[48]) ? hka_pkg::M48 : tot_sum[47:0];

	assign out_free = ~result_valid | ~result_stall;
	assign q_pop    = (st_q == ST_IDLE) & ~q_empty;

	always_ff @(posedge clk) begin
		if (q_pop)
			ent_q <= q_data;
		if (st_q == ST_MUL)
			acc_q <= ((mcnt_q == 2'd0) ? 128'd0 : acc_q) + pp_sh;
		if (st_q == ST_MFIN) begin
			case (op_q)
				OP_T:   t_q   <= sat;
				OP_ESA: esa_q <= sat;
				OP_XA:  x_q   <= sat;
				OP_VSA: vsa_q <= hka_pkg::add_sat(esa_q, sat);
				OP_TB:  tb_q  <= sat;
				OP_ESB: esb_q <= sat;
				OP_XB:  x_q   <= sat;
				OP_VSB: vsb_q <= hka_pkg::add_sat(esb_q, sat);
				OP_ED:  ed_q  <= sat;
				OP_M:   x_q   <= sat;
				OP_VD:  vd_q  <= hka_pkg::add_sat(ed_q, sat);
				default: begin
					rem_q <= acc_q[127:64];
					lo_q  <= acc_q[63:0];
					quo_q <= '0;
					case (op_q)
						OP_DA:   begin
							za_q <= (var_cur == '0);
							da_q <= (var_cur == '0) ? '0 : hka_pkg::CAP;
						end
						OP_DB:   begin
							zb_q <= (var_cur == '0);
							nb_q <= (acc_q == '0);
							db_q <= (var_cur == '0) ? '0 : hka_pkg::CAP;
						end
						default: begin
							zd_q <= (var_cur == '0);
							dd_q <= (var_cur == '0) ? '0 : hka_pkg::CAP;
						end
					endcase
				end
			endcase
		end
		if (st_q == ST_DIV) begin
			rem_q <= ge ? rem_n - var_cur : rem_n;
			lo_q  <= {lo_q[62:0], 1'b0};
			quo_q <= quo_n;
			if (dcnt_q == '1) begin
				case (op_q)
					OP_DA:   da_q <= (quo_n > hka_pkg::CAP) ? hka_pkg::CAP : quo_n;
					OP_DB:   db_q <= (quo_n > hka_pkg::CAP) ? hka_pkg::CAP : quo_n;
					default: dd_q <= (quo_n > hka_pkg::CAP) ? hka_pkg::CAP : quo_n;
				endcase
			end
		end
		if (st_q == ST_DONE && out_free) begin
			result.chi_locus   <= chi48;
			result.expected_sa <= (esa_q > 64'(hka_pkg::M48)) ? hka_pkg::M48 : esa_q[47:0];
			result.expected_d  <= (ed_q > 64'(hka_pkg::M48)) ? hka_pkg::M48 : ed_q[47:0];
			result.chi_total   <= tot48;
			result.invalid     <= bad;
			result.last_out    <= ent_q.last_locus;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			op_q         <= OP_T;
			mcnt_q       <= '0;
			dcnt_q       <= '0;
			total_q      <= '0;
			result_valid <= 1'b0;
		end else begin
			if (st_q == ST_DONE && out_free)
				result_valid <= 1'b1;
			else if (result_valid && !result_stall)
				result_valid <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (!q_empty) begin
						op_q   <= OP_T;
						mcnt_q <= '0;
						st_q   <= ST_MUL;
					end
				end
				ST_MUL: begin
					mcnt_q <= mcnt_q + 1'b1;
					if (mcnt_q == 2'd3)
						st_q <= ST_MFIN;
				end
				ST_MFIN: begin
					if (op_q < OP_DA) begin
						op_q <= op_q + 1'b1;
						st_q <= ST_MUL;
					end else if (var_cur != '0 && acc_q[127:64] < var_cur) begin
						dcnt_q <= '0;
						st_q   <= ST_DIV;
					end else if (op_q == OP_DD) begin
						st_q <= ST_DONE;
					end else begin
						op_q <= op_q + 1'b1;
						st_q <= ST_MUL;
					end
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == '1) begin
						if (op_q == OP_DD) begin
							st_q <= ST_DONE;
						end else begin
							op_q <= op_q + 1'b1;
							st_q <= ST_MUL;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						total_q <= ent_q.last_locus ? '0 : tot48;
						st_q    <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule
